// ===== design/ipr_pkg.sv =====
// Shared types and constants of the IPS patch record parser.
// No dependencies; compiled first.
`default_nettype none

package ipr_pkg;

    localparam logic [23:0] EOF_MARK = 24'h454F46;

    typedef enum logic [3:0] {
        PH_HEADER   = 4'd0,
        PH_OFFSET   = 4'd1,
        PH_LENGTH   = 4'd2,
        PH_RCOUNT   = 4'd3,
        PH_RVALUE   = 4'd4,
        PH_DATA     = 4'd5,
        PH_TRUNC    = 4'd6,
        PH_IGNORE   = 4'd7,
        PH_FINISHED = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_FILL  = 3'd1,
        CMD_TRUNC = 3'd2,
        CMD_DONE  = 3'd3,
        CMD_BADHD = 3'd4,
        CMD_UNEXP = 3'd5
    } t_cmd;

    typedef struct packed {
        t_cmd        command;
        logic [24:0] target_address;
        logic [15:0] run_count;
        logic [7:0]  data_byte;
        logic [23:0] new_size;
    } t_result;

    // Expected header bytes "PATCH"
    function automatic logic [7:0] f_magic(input logic [2:0] idx);
        logic [7:0] v;
        v = 8'h00;
        case (idx)
            3'd0:    v = 8'h50;
            3'd1:    v = 8'h41;
            3'd2:    v = 8'h54;
            3'd3:    v = 8'h43;
            3'd4:    v = 8'h48;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== design/ipr_stream_if.sv =====
// Valid/ready channel interfaces of the IPS patch record parser.
// Depend on nothing; the parser's top level uses both.
`default_nettype none

interface ipr_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] patch_byte;

    modport source (output valid, output kind, output patch_byte, input ready);
    modport sink   (input valid, input kind, input patch_byte, output ready);
endinterface

interface ipr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [24:0] target_address;
    logic [15:0] run_count;
    logic [7:0]  data_byte;
    logic [23:0] new_size;

    modport source (output valid, output command, output target_address,
                    output run_count, output data_byte, output new_size,
                    input ready);
    modport sink   (input valid, input command, input target_address,
                    input run_count, input data_byte, input new_size,
                    output ready);
endinterface

`default_nettype wire

// ===== design/ipr_core.sv =====
// Parser state and per-byte field assembly of the IPS patch record parser.
// Depends on ipr_pkg.
`default_nettype none

module ipr_core
    import ipr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_accept,
    input  wire logic    i_kind,
    input  wire logic [7:0] i_byte,
    output logic         o_res_valid,
    output t_result      o_res
);

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_idx,    n_idx;
    logic [23:0] r_offset, n_offset;
    logic [15:0] r_length, n_length;
    logic [15:0] r_done,   n_done;
    logic [23:0] r_size,   n_size;
    logic        r_err,    n_err;

    logic [23:0] w_off_shift;
    logic [15:0] w_len_shift;
    logic [23:0] w_size_shift;
    logic [15:0] w_done_inc;
    logic [24:0] w_wr_addr;
    logic        w_trunc_empty;

    assign w_off_shift   = {r_offset[15:0], i_byte};
    assign w_len_shift   = {r_length[7:0], i_byte};
    assign w_size_shift  = {r_size[15:0], i_byte};
    assign w_done_inc    = r_done + 16'd1;
    assign w_wr_addr     = {1'b0, r_offset} + {9'd0, r_done};
    assign w_trunc_empty = (r_phase == PH_TRUNC) && (r_idx == 3'd0);

    // Next state
    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_offset = r_offset;
        n_length = r_length;
        n_done   = r_done;
        n_size   = r_size;
        n_err    = r_err;
        if (i_accept && !r_err && r_phase != PH_FINISHED) begin
            if (i_kind) begin
                if (r_phase == PH_IGNORE || w_trunc_empty) begin
                    n_phase = PH_FINISHED;
                end else begin
                    n_err = 1'b1;
                end
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if (r_idx > 3'd4 || i_byte != f_magic(r_idx)) begin
                            n_err = 1'b1;
                        end else if (r_idx == 3'd4) begin
                            n_phase  = PH_OFFSET;
                            n_idx    = 3'd0;
                            n_offset = 24'd0;
                        end else begin
                            n_idx = r_idx + 3'd1;
                        end
                    end
                    PH_OFFSET: begin
                        n_offset = w_off_shift;
                        n_idx    = r_idx + 3'd1;
                        if (r_idx >= 3'd2) begin
                            n_idx = 3'd0;
                            if (w_off_shift == EOF_MARK) begin
                                n_phase = PH_TRUNC;
                                n_size  = 24'd0;
                            end else begin
                                n_phase  = PH_LENGTH;
                                n_length = 16'd0;
                            end
                        end
                    end
                    PH_LENGTH: begin
                        n_length = w_len_shift;
                        n_idx    = r_idx + 3'd1;
                        if (r_idx >= 3'd1) begin
                            n_idx   = 3'd0;
                            n_done  = 16'd0;
                            n_phase = (w_len_shift == 16'd0) ? PH_RCOUNT : PH_DATA;
                        end
                    end
                    PH_RCOUNT: begin
                        n_length = w_len_shift;
                        n_idx    = r_idx + 3'd1;
                        if (r_idx >= 3'd1) begin
                            n_idx   = 3'd0;
                            n_phase = PH_RVALUE;
                        end
                    end
                    PH_RVALUE: begin
                        n_phase  = PH_OFFSET;
                        n_idx    = 3'd0;
                        n_offset = 24'd0;
                    end
                    PH_DATA: begin
                        n_done = w_done_inc;
                        if (w_done_inc == r_length) begin
                            n_phase  = PH_OFFSET;
                            n_idx    = 3'd0;
                            n_offset = 24'd0;
                        end
                    end
                    PH_TRUNC: begin
                        n_size = w_size_shift;
                        n_idx  = r_idx + 3'd1;
                        if (r_idx >= 3'd2) begin
                            n_idx   = 3'd0;
                            n_phase = PH_IGNORE;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // Result of the accepted transaction
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        if (i_accept && !r_err && r_phase != PH_FINISHED) begin
            if (i_kind) begin
                o_res_valid = 1'b1;
                if (r_phase == PH_HEADER) begin
                    o_res.command = CMD_BADHD;
                end else if (r_phase == PH_IGNORE || w_trunc_empty) begin
                    o_res.command = CMD_DONE;
                end else begin
                    o_res.command = CMD_UNEXP;
                end
            end else begin
                unique case (r_phase)
                    PH_HEADER: begin
                        if (r_idx > 3'd4 || i_byte != f_magic(r_idx)) begin
                            o_res_valid   = 1'b1;
                            o_res.command = CMD_BADHD;
                        end
                    end
                    PH_RVALUE: begin
                        if (r_length != 16'd0) begin
                            o_res_valid          = 1'b1;
                            o_res.command        = CMD_FILL;
                            o_res.target_address = {1'b0, r_offset};
                            o_res.run_count      = r_length;
                            o_res.data_byte      = i_byte;
                        end
                    end
                    PH_DATA: begin
                        o_res_valid          = 1'b1;
                        o_res.command        = CMD_WRITE;
                        o_res.target_address = w_wr_addr;
                        o_res.data_byte      = i_byte;
                    end
                    PH_TRUNC: begin
                        if (r_idx >= 3'd2) begin
                            o_res_valid    = 1'b1;
                            o_res.command  = CMD_TRUNC;
                            o_res.new_size = w_size_shift;
                        end
                    end
                    default: begin
                        o_res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_idx    <= 3'd0;
            r_offset <= 24'd0;
            r_length <= 16'd0;
            r_done   <= 16'd0;
            r_size   <= 24'd0;
            r_err    <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_offset <= n_offset;
            r_length <= n_length;
            r_done   <= n_done;
            r_size   <= n_size;
            r_err    <= n_err;
        end
    end

    // An error holds until reset
    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("error flag cleared without reset");

    // Once done, the parser stays finished
    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FINISHED) |=> (r_phase == PH_FINISHED))
        else $error("parser left finished phase");

    // No result after an error, and none without a transaction
    a_res_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (i_accept && !r_err && r_phase != PH_FINISHED))
        else $error("result without a live transaction");

endmodule

`default_nettype wire

// ===== design/ips_patch_record_parser_unit.sv =====
// IPS patch record parser: takes an IPS patch one byte per transaction, checks
// the PATCH header, parses offset/length records, run records and the EOF
// marker with optional truncate size, and emits write, fill, truncate, done
// and error commands. One byte is taken every cycle: the parser core turns
// each byte into its next state and at most one command in the same cycle,
// and the command lands in an output register backed by a one-entry skid
// stage, so the input stalls only while both of those hold commands that the
// sink has not taken. A command appears at the output in the cycle after the
// byte that causes it when the output register is free or drains in that
// cycle; otherwise it waits in the skid stage until the sink takes the one
// ahead of it. After done or an error all input is absorbed without result
// until reset. Depends on ipr_pkg, ipr_stream_if and ipr_core.
`default_nettype none

module ips_patch_record_parser_unit
    import ipr_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ipr_in_if.sink      i_patch,
    ipr_out_if.source   o_cmd
);

    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    logic    w_take;

    logic    r_out_vld;
    t_result r_out;
    logic    r_skid_vld;
    t_result r_skid;

    assign i_patch.ready = !r_skid_vld;
    assign w_accept      = i_patch.valid && !r_skid_vld;
    assign w_take        = r_out_vld && o_cmd.ready;

    ipr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_kind      (i_patch.kind),
        .i_byte      (i_patch.patch_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            // Advance the skid entry once the output drains
            if (w_take) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (w_res_valid) begin
            if (!r_out_vld || w_take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_res_valid) begin
            if (!r_out_vld || w_take) begin
                r_out <= w_res;
            end else begin
                r_skid <= w_res;
            end
        end
    end

    assign o_cmd.valid          = r_out_vld;
    assign o_cmd.command        = r_out.command;
    assign o_cmd.target_address = r_out.target_address;
    assign o_cmd.run_count      = r_out.run_count;
    assign o_cmd.data_byte      = r_out.data_byte;
    assign o_cmd.new_size       = r_out.new_size;

    // The skid entry is only ever filled behind a held output
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry valid with empty output register");

    // A result that meets a stalled output is parked, not dropped
    a_park_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && r_out_vld && !o_cmd.ready) |=> r_skid_vld)
        else $error("result lost on stalled output");

    // A new result reaches the output register in the next cycle
    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && (!r_out_vld || o_cmd.ready)) |=> r_out_vld)
        else $error("result not registered");

endmodule

`default_nettype wire
